// ===== rtl/asa_pkg.sv =====
`default_nettype none

package asa_pkg;

   // Default geometry
   localparam int CHANNELS_DEF   = 8;
   localparam int RING_DEPTH_DEF = 16;

   // Field widths
   localparam int SAMPLE_W    = 16;
   localparam int QUERY_W     = 4;
   localparam int PCH_W       = 3;
   localparam int SLOT_W      = 3;
   localparam int CMD_W       = 16;
   localparam int AVG_W       = 16;
   localparam int ECOUNT_W    = 32;
   localparam int GAIN_W      = 20;
   localparam int OFFSET_W    = 20;
   localparam int PRESS_W     = 24;
   localparam int SUM_MAX_W   = 24;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 20;

   // Converter command: fixed bits plus channel field
   localparam logic [CMD_W-1:0] CMD_BASE     = 16'hF020;
   localparam int               CMD_CH_SHIFT = 9;

   // Q16 rounding of the pressure product
   localparam int          Q_SHIFT    = 16;
   localparam logic [15:0] ROUND_HALF = 16'h8000;

   // Item kinds
   localparam logic MODE_SCAN  = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_PRESSURE_CHANNEL = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRESSURE_GAIN    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRESSURE_OFFSET  = 2'd2;

   // Register reset values
   localparam logic [PCH_W-1:0]    PRESSURE_CHANNEL_RST = 3'd0;
   localparam logic [GAIN_W-1:0]   PRESSURE_GAIN_RST    = 20'd249532;
   localparam logic [OFFSET_W-1:0] PRESSURE_OFFSET_RST  = 20'd20000;

   typedef struct packed {
      logic                mode;
      logic [SAMPLE_W-1:0] rx_sample;
      logic                transfer_error;
      logic [QUERY_W-1:0]  query_channel;
   } req_word_type;

   // Between the channel-state stage and the output pipeline
   typedef struct packed {
      logic [CMD_W-1:0]     command_word;
      logic [SLOT_W-1:0]    written_slot;
      logic [SUM_MAX_W-1:0] sum;
      logic [ECOUNT_W-1:0]  error_count;
      logic                 status;
   } mid_word_type;

   typedef struct packed {
      logic [CMD_W-1:0]          command_word;
      logic [SLOT_W-1:0]         written_slot;
      logic [AVG_W-1:0]          average;
      logic [ECOUNT_W-1:0]       error_count;
      logic                      status;
      logic signed [PRESS_W-1:0] pressure;
   } rsp_word_type;

endpackage

`default_nettype wire

// ===== rtl/asa_req_if.sv =====
`default_nettype none

interface asa_req_if;
   logic                          valid;
   logic                          ready;
   logic                          mode;
   logic [asa_pkg::SAMPLE_W-1:0]  rx_sample;
   logic                          transfer_error;
   logic [asa_pkg::QUERY_W-1:0]   query_channel;

   modport source (
      output valid, mode, rx_sample, transfer_error, query_channel,
      input  ready
   );

   modport sink (
      input  valid, mode, rx_sample, transfer_error, query_channel,
      output ready
   );
endinterface

`default_nettype wire

// ===== rtl/asa_rsp_if.sv =====
`default_nettype none

interface asa_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [asa_pkg::CMD_W-1:0]            command_word;
   logic [asa_pkg::SLOT_W-1:0]           written_slot;
   logic [asa_pkg::AVG_W-1:0]            average;
   logic [asa_pkg::ECOUNT_W-1:0]         error_count;
   logic                                 status;
   logic signed [asa_pkg::PRESS_W-1:0]   pressure;

   modport source (
      output valid, command_word, written_slot, average, error_count, status, pressure,
      input  ready
   );

   modport sink (
      input  valid, command_word, written_slot, average, error_count, status, pressure,
      output ready
   );
endinterface

`default_nettype wire

// ===== rtl/asa_front.sv =====
`default_nettype none

// Scan sequencing, sample rings and per-channel state.
// Stage 0 (accept): pick slot, read ring entry, bump write pointer.
// Stage 1 (commit): update running sum / error count, build mid word.
module asa_front #(
   parameter int  CHANNELS   = asa_pkg::CHANNELS_DEF,
   parameter int  RING_DEPTH = asa_pkg::RING_DEPTH_DEF,
   localparam int SUM_W      = asa_pkg::SAMPLE_W + $clog2(RING_DEPTH)
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire asa_pkg::req_word_type        req_word,
   input  wire logic [asa_pkg::PCH_W-1:0]    pressure_channel_next,
   output logic                              mid_valid,
   input  wire logic                         mid_ready,
   output asa_pkg::mid_word_type             mid_word,
   output logic [SUM_W-1:0]                  press_sum
);

   localparam int CH_W   = $clog2(CHANNELS);
   localparam int WP_W   = $clog2(RING_DEPTH);
   localparam int DEPTH  = CHANNELS * RING_DEPTH;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int PCHX_W = asa_pkg::PCH_W + 1;

   // channel state
   logic [CH_W-1:0]               scan_ch_ff, scan_ch_in;
   logic [WP_W-1:0]               wp_ff [CHANNELS];
   logic [CHANNELS-1:0]           wrapped_ff;
   logic [SUM_W-1:0]              sum_ff [CHANNELS];
   logic [asa_pkg::ECOUNT_W-1:0]  ecount_ff [CHANNELS];
   logic [SUM_W-1:0]              press_sum_ff;

   // ring memory, one read and one write port
   logic [asa_pkg::SAMPLE_W-1:0]  sample_mem_ff [DEPTH];
   logic [asa_pkg::SAMPLE_W-1:0]  old_rd_ff;

   // stage 1
   logic                          v1_ff;
   asa_pkg::req_word_type         s1_req_ff;
   logic [CH_W-1:0]               s1_ch_ff;
   logic [CH_W-1:0]               s1_slot_ff;
   logic [ADDR_W-1:0]             s1_addr_ff;
   logic                          s1_old_ok_ff;

   logic                          accept, scan_acc, commit, s1_scan;
   logic [CH_W-1:0]               slot_now;
   logic [WP_W-1:0]               wp_now, wp_in;
   logic [ADDR_W-1:0]             addr_now;
   logic [CH_W-1:0]               q_idx, pch_idx, sum_idx, ec_idx;
   logic                          q_ok, pch_ok;
   logic [SUM_W-1:0]              sum_rd, new_sum;
   logic [asa_pkg::SAMPLE_W-1:0]  old_sample;
   logic [asa_pkg::ECOUNT_W-1:0]  ec_rd, ec_in;

   assign req_ready = !v1_ff || mid_ready;
   assign accept    = req_valid && req_ready;
   assign scan_acc  = accept && (req_word.mode == asa_pkg::MODE_SCAN);
   assign commit    = v1_ff && mid_ready;
   assign s1_scan   = (s1_req_ff.mode == asa_pkg::MODE_SCAN);

   // the converter answers two conversions late
   always_comb begin
      if (scan_ch_ff < CH_W'(2)) begin
         slot_now = scan_ch_ff + CH_W'(CHANNELS - 2);
      end else begin
         slot_now = scan_ch_ff - CH_W'(2);
      end
   end

   assign scan_ch_in = (scan_ch_ff == CH_W'(CHANNELS - 1)) ? '0 : scan_ch_ff + CH_W'(1);
   assign wp_now     = wp_ff[slot_now];
   assign wp_in      = (wp_now == WP_W'(RING_DEPTH - 1)) ? '0 : wp_now + WP_W'(1);
   assign addr_now   = ADDR_W'(slot_now) * ADDR_W'(RING_DEPTH) + ADDR_W'(wp_now);

   assign q_idx   = s1_req_ff.query_channel[CH_W-1:0];
   assign q_ok    = s1_req_ff.query_channel < asa_pkg::QUERY_W'(CHANNELS);
   assign pch_idx = pressure_channel_next[CH_W-1:0];
   assign pch_ok  = {1'b0, pressure_channel_next} < PCHX_W'(CHANNELS);

   // single read port on the sums; when stage 1 is empty it tracks the pressure channel
   assign sum_idx = v1_ff ? (s1_scan ? s1_slot_ff : q_idx) : pch_idx;
   assign sum_rd  = sum_ff[sum_idx];
   assign old_sample = s1_old_ok_ff ? old_rd_ff : '0;
   assign new_sum = sum_rd - SUM_W'(old_sample) + SUM_W'(s1_req_ff.rx_sample);

   assign ec_idx = s1_scan ? s1_ch_ff : q_idx;
   assign ec_rd  = ecount_ff[ec_idx];
   assign ec_in  = (ec_rd == '1) ? ec_rd : ec_rd + asa_pkg::ECOUNT_W'(1);

   always_comb begin
      mid_word = '0;
      if (s1_scan) begin
         mid_word.command_word = asa_pkg::CMD_BASE
            | (asa_pkg::CMD_W'(s1_ch_ff) << asa_pkg::CMD_CH_SHIFT);
         mid_word.written_slot = asa_pkg::SLOT_W'(s1_slot_ff);
      end else if (q_ok) begin
         mid_word.sum         = asa_pkg::SUM_MAX_W'(sum_rd);
         mid_word.error_count = ec_rd;
      end else begin
         mid_word.status = 1'b1;
      end
   end

   assign mid_valid = v1_ff;
   assign press_sum = press_sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         scan_ch_ff   <= '0;
         wrapped_ff   <= '0;
         press_sum_ff <= '0;
         for (int i = 0; i < CHANNELS; i++) begin
            wp_ff[i]     <= '0;
            sum_ff[i]    <= '0;
            ecount_ff[i] <= '0;
         end
      end else begin
         if (req_ready) begin
            v1_ff <= req_valid;
         end
         if (scan_acc) begin
            scan_ch_ff      <= scan_ch_in;
            wp_ff[slot_now] <= wp_in;
            if (wp_now == WP_W'(RING_DEPTH - 1)) begin
               wrapped_ff[slot_now] <= 1'b1;
            end
         end
         if (commit && s1_scan) begin
            sum_ff[s1_slot_ff] <= new_sum;
            if (s1_req_ff.transfer_error) begin
               ecount_ff[s1_ch_ff] <= ec_in;
            end
         end
         if (commit && s1_scan && pch_ok && (s1_slot_ff == pch_idx)) begin
            press_sum_ff <= new_sum;
         end else if (!v1_ff) begin
            press_sum_ff <= pch_ok ? sum_rd : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_req_ff    <= req_word;
         s1_ch_ff     <= scan_ch_ff;
         s1_slot_ff   <= slot_now;
         s1_addr_ff   <= addr_now;
         s1_old_ok_ff <= wrapped_ff[slot_now];
      end
   end

   always_ff @(posedge clock) begin
      if (scan_acc) begin
         old_rd_ff <= sample_mem_ff[addr_now];
      end
   end

   always_ff @(posedge clock) begin
      if (commit && s1_scan) begin
         sample_mem_ff[s1_addr_ff] <= s1_req_ff.rx_sample;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/asa_back.sv =====
`default_nettype none

// Average division by reciprocal, pressure gain, rounding and offset.
// Stages: s2 (reciprocal multiply), s3 (gain multiply), s4 (round, offset), out.
module asa_back #(
   parameter int  RING_DEPTH = asa_pkg::RING_DEPTH_DEF,
   localparam int SUM_W      = asa_pkg::SAMPLE_W + $clog2(RING_DEPTH)
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          mid_valid,
   output logic                               mid_ready,
   input  wire asa_pkg::mid_word_type         mid_word,
   input  wire logic [SUM_W-1:0]              press_sum,
   input  wire logic [asa_pkg::GAIN_W-1:0]    pressure_gain,
   input  wire logic [asa_pkg::OFFSET_W-1:0]  pressure_offset,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output asa_pkg::rsp_word_type              rsp_word
);

   // floor(x / RING_DEPTH) == (x * DIV_MUL) >> DIV_SH for every x below 2**SUM_W
   localparam int DIV_SH = SUM_W + $clog2(RING_DEPTH);
   localparam int MUL_W  = SUM_W + 1;
   localparam int PROD_W = SUM_W + MUL_W;
   localparam logic [MUL_W-1:0] DIV_MUL =
      MUL_W'(((64'd1 << DIV_SH) + 64'(RING_DEPTH) - 64'd1) / 64'(RING_DEPTH));
   localparam int GPROD_W = asa_pkg::AVG_W + asa_pkg::GAIN_W;
   localparam int RND_W   = GPROD_W + 1;
   localparam int RES_W   = RND_W - asa_pkg::Q_SHIFT;
   localparam int DIFF_W  = RES_W + 1;

   logic                  v2_ff, v3_ff, v4_ff, vo_ff;
   logic                  load2, load3, load4, load_o;
   asa_pkg::mid_word_type m2_ff, m3_ff, m4_ff;
   logic [PROD_W-1:0]     q_prod3_ff, p_prod3_ff;
   logic [asa_pkg::AVG_W-1:0]   avg4_ff;
   logic [GPROD_W-1:0]          g_prod4_ff;
   asa_pkg::rsp_word_type       rsp_ff, rsp_in;

   logic [RND_W-1:0]            rounded;
   logic [RES_W-1:0]            scaled;
   logic signed [DIFF_W-1:0]    diff;

   assign load_o    = !vo_ff || rsp_ready;
   assign load4     = !v4_ff || load_o;
   assign load3     = !v3_ff || load4;
   assign load2     = !v2_ff || load3;
   assign mid_ready = load2;

   assign rounded = RND_W'(g_prod4_ff) + RND_W'(asa_pkg::ROUND_HALF);
   assign scaled  = rounded[RND_W-1:asa_pkg::Q_SHIFT];
   assign diff    = $signed({1'b0, scaled}) - $signed(DIFF_W'(pressure_offset));

   // the offset result always lies inside the 24-bit signed range
   always_comb begin
      rsp_in              = '0;
      rsp_in.command_word = m4_ff.command_word;
      rsp_in.written_slot = m4_ff.written_slot;
      rsp_in.average      = avg4_ff;
      rsp_in.error_count  = m4_ff.error_count;
      rsp_in.status       = m4_ff.status;
      rsp_in.pressure     = asa_pkg::PRESS_W'(diff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         if (load2) begin
            v2_ff <= mid_valid;
         end
         if (load3) begin
            v3_ff <= v2_ff;
         end
         if (load4) begin
            v4_ff <= v3_ff;
         end
         if (load_o) begin
            vo_ff <= v4_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load2) begin
         m2_ff <= mid_word;
      end
      if (load3) begin
         m3_ff      <= m2_ff;
         q_prod3_ff <= PROD_W'(m2_ff.sum[SUM_W-1:0]) * PROD_W'(DIV_MUL);
         p_prod3_ff <= PROD_W'(press_sum) * PROD_W'(DIV_MUL);
      end
      if (load4) begin
         m4_ff      <= m3_ff;
         avg4_ff    <= q_prod3_ff[DIV_SH +: asa_pkg::AVG_W];
         g_prod4_ff <= GPROD_W'(p_prod3_ff[DIV_SH +: asa_pkg::AVG_W]) * GPROD_W'(pressure_gain);
      end
      if (load_o) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = vo_ff;
   assign rsp_word  = rsp_ff;

endmodule

`default_nettype wire

// ===== rtl/adc_scan_average.sv =====
// Round-robin ADC scanner with a per-channel moving average. A scan word
// (mode 0) returns the converter command for the current channel and files
// the received sample in the ring of the channel two positions back, since
// the converter answers two conversions late; a failed transfer bumps the
// saturating error count of the current channel. A query word (mode 1)
// returns the floor average of one channel's ring and its error count, or
// status 1 for a channel number past CHANNELS-1. Every response also carries
// the configured pressure channel's average scaled by a Q16 gain, rounded
// half up, minus an offset, in 0.001 mbar. The block takes one word per
// clock unless back-pressure from the response side stalls it, and returns
// one response per word, in order. The word is held in turn by a
// ring-memory read stage (loaded at the accepting edge), a state-update
// stage, a reciprocal-multiply stage, a gain-multiply stage and the
// output register. The sustained rate is set by the ring memory, which
// needs one read and one write port each cycle. Ring entries that were
// never written read as zero through a per-channel wrap flag, so there
// is no clearing pass after reset. Configuration writes are to be made
// while the block holds no words.
`default_nettype none

module adc_scan_average #(
   parameter int CHANNELS   = asa_pkg::CHANNELS_DEF,   // 3 to 8
   parameter int RING_DEPTH = asa_pkg::RING_DEPTH_DEF  // 2 to 256
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   asa_req_if.sink                               req_chan,
   asa_rsp_if.source                             rsp_chan,
   input  wire logic                             csr_write_enable,
   input  wire logic [asa_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [asa_pkg::CSR_DATA_W-1:0]   csr_write_data
);

   localparam int SUM_W = asa_pkg::SAMPLE_W + $clog2(RING_DEPTH);

   // configuration registers
   logic [asa_pkg::PCH_W-1:0]     pressure_channel_ff, pressure_channel_in;
   logic [asa_pkg::GAIN_W-1:0]    pressure_gain_ff, pressure_gain_in;
   logic [asa_pkg::OFFSET_W-1:0]  pressure_offset_ff, pressure_offset_in;

   asa_pkg::req_word_type  req_word;
   asa_pkg::mid_word_type  mid_word;
   asa_pkg::rsp_word_type  rsp_word;
   logic                   mid_valid, mid_ready;
   logic [SUM_W-1:0]       press_sum;

   // Register write decode; unknown indexes are dropped.
   always_comb begin
      pressure_channel_in = pressure_channel_ff;
      pressure_gain_in    = pressure_gain_ff;
      pressure_offset_in  = pressure_offset_ff;
      if (csr_write_enable) begin
         case (csr_index)
            asa_pkg::CSR_PRESSURE_CHANNEL: begin
               pressure_channel_in = csr_write_data[asa_pkg::PCH_W-1:0];
            end
            asa_pkg::CSR_PRESSURE_GAIN: begin
               pressure_gain_in = csr_write_data[asa_pkg::GAIN_W-1:0];
            end
            asa_pkg::CSR_PRESSURE_OFFSET: begin
               pressure_offset_in = csr_write_data[asa_pkg::OFFSET_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pressure_channel_ff <= asa_pkg::PRESSURE_CHANNEL_RST;
         pressure_gain_ff    <= asa_pkg::PRESSURE_GAIN_RST;
         pressure_offset_ff  <= asa_pkg::PRESSURE_OFFSET_RST;
      end else begin
         pressure_channel_ff <= pressure_channel_in;
         pressure_gain_ff    <= pressure_gain_in;
         pressure_offset_ff  <= pressure_offset_in;
      end
   end

   // input word
   always_comb begin
      req_word.mode           = req_chan.mode;
      req_word.rx_sample      = req_chan.rx_sample;
      req_word.transfer_error = req_chan.transfer_error;
      req_word.query_channel  = req_chan.query_channel;
   end

   // Front end: scan pointer, rings, running sums, error counters. The pressure
   // channel's sum is shadowed there; the next-value of the channel register is
   // passed so the shadow follows a write at once while stage 1 is empty.
   asa_front #(
      .CHANNELS   (CHANNELS),
      .RING_DEPTH (RING_DEPTH)
   ) u_front (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_chan.valid),
      .req_ready             (req_chan.ready),
      .req_word              (req_word),
      .pressure_channel_next (pressure_channel_in),
      .mid_valid             (mid_valid),
      .mid_ready             (mid_ready),
      .mid_word              (mid_word),
      .press_sum             (press_sum)
   );

   // Back end: averages, pressure conversion, output register.
   asa_back #(
      .RING_DEPTH (RING_DEPTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .mid_valid       (mid_valid),
      .mid_ready       (mid_ready),
      .mid_word        (mid_word),
      .press_sum       (press_sum),
      .pressure_gain   (pressure_gain_ff),
      .pressure_offset (pressure_offset_ff),
      .rsp_valid       (rsp_chan.valid),
      .rsp_ready       (rsp_chan.ready),
      .rsp_word        (rsp_word)
   );

   // response word
   assign rsp_chan.command_word = rsp_word.command_word;
   assign rsp_chan.written_slot = rsp_word.written_slot;
   assign rsp_chan.average      = rsp_word.average;
   assign rsp_chan.error_count  = rsp_word.error_count;
   assign rsp_chan.status       = rsp_word.status;
   assign rsp_chan.pressure     = rsp_word.pressure;

endmodule

`default_nettype wire
